// File: rtl/stok_pkg.sv
// shared types and constants for the source tokenizer
`default_nettype none

package stok_pkg;

  localparam int KIND_W  = 5;
  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_STR   = 3'd3,
    MODE_MINUS = 3'd4,
    MODE_EQ    = 3'd5,
    MODE_BAR   = 3'd6
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT    = 5'd0,
    KIND_FLOAT    = 5'd1,
    KIND_INT      = 5'd2,
    KIND_LPAREN   = 5'd3,
    KIND_RPAREN   = 5'd4,
    KIND_LCURLY   = 5'd5,
    KIND_RCURLY   = 5'd6,
    KIND_SEMI     = 5'd7,
    KIND_PLUS     = 5'd8,
    KIND_MINUS    = 5'd9,
    KIND_ARROW    = 5'd10,
    KIND_STAR     = 5'd11,
    KIND_SLASH    = 5'd12,
    KIND_COLON    = 5'd13,
    KIND_COMMA    = 5'd14,
    KIND_EQ       = 5'd15,
    KIND_EQEQ     = 5'd16,
    KIND_PIPEPIPE = 5'd17,
    KIND_BAR      = 5'd18,
    KIND_STRING   = 5'd19,
    KIND_EOF      = 5'd20,
    KIND_UNKNOWN  = 5'd21
  } kind_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

endpackage

`default_nettype wire

// File: rtl/stok_scan.sv
// scanner state machine: per-byte decision, counters and token records
`default_nettype none

module stok_scan #(
  parameter int POS_WIDTH  = 16,
  parameter int LINE_WIDTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          step,
  input  wire logic [7:0]                                    ch,
  input  wire logic                                          has_byte,
  input  wire logic                                          eos,
  output logic [stok_pkg::MAX_RES-1:0]                       rec_vld,
  output logic [stok_pkg::MAX_RES-1:0][stok_pkg::KIND_W-1:0] rec_kind,
  output logic [stok_pkg::MAX_RES-1:0][POS_WIDTH-1:0]        rec_start,
  output logic [stok_pkg::MAX_RES-1:0][POS_WIDTH-1:0]        rec_len,
  output logic [stok_pkg::MAX_RES-1:0][LINE_WIDTH-1:0]       rec_line,
  output logic [stok_pkg::MAX_RES-1:0]                       rec_last
);

  localparam logic [POS_WIDTH-1:0]  POS_MAX  = {POS_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

  stok_pkg::mode_t       mode_r, mode_nxt, mode_a;
  logic                  dot_r, dot_nxt, dot_a;
  logic [POS_WIDTH-1:0]  tstart_r, tstart_nxt, tstart_a;
  logic [POS_WIDTH-1:0]  pos_r, pos_nxt, pos_a, pos_inc;
  logic [LINE_WIDTH-1:0] line_r, line_nxt, line_a, line_inc;
  logic [LINE_WIDTH-1:0] tline_r, tline_nxt, tline_a;

  logic is_alpha, is_digit, is_alnum, is_dot, is_quote, is_lf, is_ws;
  logic is_minus, is_eq, is_bar, is_gt;
  logic take_idle, ib_emit;

  stok_pkg::kind_t       a_kind, m_kind;
  logic                  a_vld, m_vld;
  logic [POS_WIDTH-1:0]  a_start, a_len, m_start, m_len;
  logic [LINE_WIDTH-1:0] a_line, m_line;

  function automatic logic [POS_WIDTH-1:0] span(input logic [POS_WIDTH-1:0] e,
                                                input logic [POS_WIDTH-1:0] s);
    span = (e >= s) ? e - s : '0;
  endfunction

  function automatic stok_pkg::kind_t punct_kind(input logic [7:0] c);
    stok_pkg::kind_t k;
    unique case (c)
      stok_pkg::CH_LPAREN: k = stok_pkg::KIND_LPAREN;
      stok_pkg::CH_RPAREN: k = stok_pkg::KIND_RPAREN;
      stok_pkg::CH_LCURLY: k = stok_pkg::KIND_LCURLY;
      stok_pkg::CH_RCURLY: k = stok_pkg::KIND_RCURLY;
      stok_pkg::CH_SEMI:   k = stok_pkg::KIND_SEMI;
      stok_pkg::CH_PLUS:   k = stok_pkg::KIND_PLUS;
      stok_pkg::CH_STAR:   k = stok_pkg::KIND_STAR;
      stok_pkg::CH_SLASH:  k = stok_pkg::KIND_SLASH;
      stok_pkg::CH_COLON:  k = stok_pkg::KIND_COLON;
      stok_pkg::CH_COMMA:  k = stok_pkg::KIND_COMMA;
      default:             k = stok_pkg::KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // byte classes
  assign is_alpha = (ch >= stok_pkg::CH_LA && ch <= stok_pkg::CH_LZ) ||
                    (ch >= stok_pkg::CH_UA && ch <= stok_pkg::CH_UZ);
  assign is_digit = ch >= stok_pkg::CH_D0 && ch <= stok_pkg::CH_D9;
  assign is_alnum = is_alpha || is_digit;
  assign is_dot   = ch == stok_pkg::CH_DOT;
  assign is_quote = ch == stok_pkg::CH_QUOTE;
  assign is_lf    = ch == stok_pkg::CH_LF;
  assign is_ws    = ch == stok_pkg::CH_SPACE || ch == stok_pkg::CH_TAB ||
                    ch == stok_pkg::CH_CR;
  assign is_minus = ch == stok_pkg::CH_MINUS;
  assign is_eq    = ch == stok_pkg::CH_EQ;
  assign is_bar   = ch == stok_pkg::CH_BAR;
  assign is_gt    = ch == stok_pkg::CH_GT;

  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + POS_WIDTH'(1);
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + LINE_ONE;
  assign pos_a    = has_byte ? pos_inc : pos_r;

  // effect of the byte on the scan state
  always_comb begin
    mode_a    = mode_r;
    dot_a     = dot_r;
    tstart_a  = tstart_r;
    tline_a   = tline_r;
    line_a    = line_r;
    take_idle = 1'b0;
    if (has_byte) begin
      unique case (mode_r)
        stok_pkg::MODE_IDLE:  take_idle = 1'b1;
        stok_pkg::MODE_IDENT: take_idle = !is_alnum;
        stok_pkg::MODE_NUM: begin
          if (is_dot) dot_a = 1'b1;
          take_idle = !(is_dot || is_digit);
        end
        stok_pkg::MODE_STR: begin
          if (is_quote) mode_a = stok_pkg::MODE_IDLE;
        end
        stok_pkg::MODE_MINUS: begin
          mode_a    = stok_pkg::MODE_IDLE;
          take_idle = !is_gt;
        end
        stok_pkg::MODE_EQ: begin
          mode_a    = stok_pkg::MODE_IDLE;
          take_idle = !is_eq;
        end
        stok_pkg::MODE_BAR: begin
          mode_a    = stok_pkg::MODE_IDLE;
          take_idle = !is_bar;
        end
        default: take_idle = 1'b1;
      endcase
      if (take_idle) begin
        mode_a = stok_pkg::MODE_IDLE;
        priority if (is_lf) begin
          line_a = line_inc;
        end else if (is_minus) begin
          mode_a   = stok_pkg::MODE_MINUS;
          tstart_a = pos_r;
          tline_a  = line_r;
        end else if (is_eq) begin
          mode_a   = stok_pkg::MODE_EQ;
          tstart_a = pos_r;
          tline_a  = line_r;
        end else if (is_bar) begin
          mode_a   = stok_pkg::MODE_BAR;
          tstart_a = pos_r;
          tline_a  = line_r;
        end else if (is_quote) begin
          mode_a   = stok_pkg::MODE_STR;
          tstart_a = pos_inc;
          tline_a  = line_r;
        end else if (is_alpha) begin
          mode_a   = stok_pkg::MODE_IDENT;
          tstart_a = pos_r;
          tline_a  = line_r;
        end else if (is_digit) begin
          mode_a   = stok_pkg::MODE_NUM;
          dot_a    = 1'b0;
          tstart_a = pos_r;
          tline_a  = line_r;
        end else begin
          mode_a = stok_pkg::MODE_IDLE;
        end
      end
    end
  end

  assign ib_emit = take_idle && !(is_lf || is_ws || is_minus || is_eq || is_bar ||
                                  is_quote || is_alpha || is_digit);

  // next state: end of source returns to the reset state
  always_comb begin
    if (eos) begin
      mode_nxt   = stok_pkg::MODE_IDLE;
      dot_nxt    = 1'b0;
      tstart_nxt = '0;
      pos_nxt    = '0;
      line_nxt   = LINE_ONE;
      tline_nxt  = LINE_ONE;
    end else begin
      mode_nxt   = mode_a;
      dot_nxt    = dot_a;
      tstart_nxt = tstart_a;
      pos_nxt    = pos_a;
      line_nxt   = line_a;
      tline_nxt  = tline_a;
    end
  end

  // records: closed token, single-char or flushed token, eof
  always_comb begin
    a_vld   = 1'b0;
    a_kind  = stok_pkg::KIND_IDENT;
    a_start = tstart_r;
    a_len   = span(pos_r, tstart_r);
    a_line  = tline_r;
    if (has_byte) begin
      unique case (mode_r)
        stok_pkg::MODE_STR: begin
          a_vld  = is_quote;
          a_kind = stok_pkg::KIND_STRING;
        end
        stok_pkg::MODE_IDENT: begin
          a_vld  = take_idle;
          a_kind = stok_pkg::KIND_IDENT;
        end
        stok_pkg::MODE_NUM: begin
          a_vld  = take_idle;
          a_kind = dot_r ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT;
        end
        stok_pkg::MODE_MINUS: begin
          a_vld  = 1'b1;
          a_kind = is_gt ? stok_pkg::KIND_ARROW : stok_pkg::KIND_MINUS;
          a_len  = is_gt ? POS_WIDTH'(2) : POS_WIDTH'(1);
        end
        stok_pkg::MODE_EQ: begin
          a_vld  = 1'b1;
          a_kind = is_eq ? stok_pkg::KIND_EQEQ : stok_pkg::KIND_EQ;
          a_len  = is_eq ? POS_WIDTH'(2) : POS_WIDTH'(1);
        end
        stok_pkg::MODE_BAR: begin
          a_vld  = 1'b1;
          a_kind = is_bar ? stok_pkg::KIND_PIPEPIPE : stok_pkg::KIND_BAR;
          a_len  = is_bar ? POS_WIDTH'(2) : POS_WIDTH'(1);
        end
        default: a_vld = 1'b0;
      endcase
    end

    m_vld   = 1'b0;
    m_kind  = punct_kind(ch);
    m_start = pos_r;
    m_len   = POS_WIDTH'(1);
    m_line  = line_r;
    if (has_byte && ib_emit) begin
      m_vld = 1'b1;
    end else if (eos && mode_a != stok_pkg::MODE_IDLE) begin
      m_vld   = 1'b1;
      m_start = tstart_a;
      m_line  = tline_a;
      m_len   = span(pos_a, tstart_a);
      unique case (mode_a)
        stok_pkg::MODE_IDENT: m_kind = stok_pkg::KIND_IDENT;
        stok_pkg::MODE_NUM:
          m_kind = dot_a ? stok_pkg::KIND_FLOAT : stok_pkg::KIND_INT;
        stok_pkg::MODE_STR:   m_kind = stok_pkg::KIND_STRING;
        stok_pkg::MODE_MINUS: begin
          m_kind = stok_pkg::KIND_MINUS;
          m_len  = POS_WIDTH'(1);
        end
        stok_pkg::MODE_EQ: begin
          m_kind = stok_pkg::KIND_EQ;
          m_len  = POS_WIDTH'(1);
        end
        stok_pkg::MODE_BAR: begin
          m_kind = stok_pkg::KIND_BAR;
          m_len  = POS_WIDTH'(1);
        end
        default: m_vld = 1'b0;
      endcase
    end
  end

  assign rec_vld   = {eos, m_vld, a_vld};
  assign rec_kind  = {stok_pkg::KIND_EOF, m_kind, a_kind};
  assign rec_start = {pos_a, m_start, a_start};
  assign rec_len   = {{POS_WIDTH{1'b0}}, m_len, a_len};
  assign rec_line  = {line_a, m_line, a_line};
  assign rec_last  = {1'b1, !eos, !(eos || m_vld)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stok_pkg::MODE_IDLE;
      dot_r    <= 1'b0;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= LINE_ONE;
      tline_r  <= LINE_ONE;
    end else if (step) begin
      mode_r   <= mode_nxt;
      dot_r    <= dot_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tline_r  <= tline_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stok_rq.sv
// result queue: takes up to three records per cycle, delivers one per cycle while out_ready is high
`default_nettype none

module stok_rq #(
  parameter int POS_WIDTH  = 16,
  parameter int LINE_WIDTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          push,
  input  wire logic [stok_pkg::MAX_RES-1:0]                  rec_vld,
  input  wire logic [stok_pkg::MAX_RES-1:0][stok_pkg::KIND_W-1:0] rec_kind,
  input  wire logic [stok_pkg::MAX_RES-1:0][POS_WIDTH-1:0]   rec_start,
  input  wire logic [stok_pkg::MAX_RES-1:0][POS_WIDTH-1:0]   rec_len,
  input  wire logic [stok_pkg::MAX_RES-1:0][LINE_WIDTH-1:0]  rec_line,
  input  wire logic [stok_pkg::MAX_RES-1:0]                  rec_last,
  output logic                                               room,
  output logic                                               out_valid,
  input  wire logic                                          out_ready,
  output logic [stok_pkg::KIND_W-1:0]                        out_token_kind,
  output logic [POS_WIDTH-1:0]                               out_start_pos,
  output logic [POS_WIDTH-1:0]                               out_token_len,
  output logic [LINE_WIDTH-1:0]                              out_line,
  output logic                                               out_last
);

  localparam int DEPTH = 8;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int ENT_W = stok_pkg::KIND_W + 2 * POS_WIDTH + LINE_WIDTH + 1;

  logic [ENT_W-1:0] ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_push;
  logic [stok_pkg::MAX_RES-1:0][PTR_W-1:0] off;
  logic [stok_pkg::MAX_RES-1:0][ENT_W-1:0] ent_in;
  logic             pop;

  assign off[0] = '0;
  assign off[1] = PTR_W'(rec_vld[0]);
  assign off[2] = PTR_W'(rec_vld[0]) + PTR_W'(rec_vld[1]);

  always_comb begin
    for (int i = 0; i < stok_pkg::MAX_RES; i++) begin
      ent_in[i] = {rec_kind[i], rec_start[i], rec_len[i], rec_line[i], rec_last[i]};
    end
  end

  assign n_push = push ? CNT_W'(rec_vld[0]) + CNT_W'(rec_vld[1]) + CNT_W'(rec_vld[2])
                       : '0;
  assign pop        = out_valid && out_ready;
  assign cnt_nxt    = cnt_r + n_push - CNT_W'(pop);
  assign wr_ptr_nxt = wr_ptr_r + n_push[PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign room       = cnt_r <= CNT_W'(DEPTH - stok_pkg::MAX_RES);
  assign out_valid  = cnt_r != '0;

  assign {out_token_kind, out_start_pos, out_token_len, out_line, out_last} = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < stok_pkg::MAX_RES; i++) begin
      if (push && rec_vld[i]) begin
        ent_r[wr_ptr_r + off[i]] <= ent_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/source_tokenizer_core.sv
// source tokenizer top level: input register, scanner and result queue
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_ch, in_has_byte, in_end_of_source
//   out      output     out_valid / out_ready  out_token_kind, out_start_pos,
//                                              out_token_len, out_line, out_last
//
// one item a cycle enters the input register while in_ready is high; the scanner
// decides it once the queue has room and writes up to three records into an
// eight-entry result queue; the queue delivers one record a cycle while out_ready is high
// an item is scanned only while the queue has room for three records
// reset returns the scanner to the start of a source and empties the queue
`default_nettype none

module source_tokenizer_core #(
  parameter int POS_WIDTH  = 16,
  parameter int LINE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_ch,
  input  wire logic                          in_has_byte,
  input  wire logic                          in_end_of_source,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [stok_pkg::KIND_W-1:0]        out_token_kind,
  output logic [POS_WIDTH-1:0]               out_start_pos,
  output logic [POS_WIDTH-1:0]               out_token_len,
  output logic [LINE_WIDTH-1:0]              out_line,
  output logic                               out_last
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_ch_r;
  logic       in_has_r, in_eos_r;
  logic       room, proc, load;

  logic [stok_pkg::MAX_RES-1:0]                       rec_vld;
  logic [stok_pkg::MAX_RES-1:0][stok_pkg::KIND_W-1:0] rec_kind;
  logic [stok_pkg::MAX_RES-1:0][POS_WIDTH-1:0]        rec_start;
  logic [stok_pkg::MAX_RES-1:0][POS_WIDTH-1:0]        rec_len;
  logic [stok_pkg::MAX_RES-1:0][LINE_WIDTH-1:0]       rec_line;
  logic [stok_pkg::MAX_RES-1:0]                       rec_last;

  assign proc       = in_vld_r && room;
  assign in_ready   = !in_vld_r || proc;
  assign load       = in_valid && in_ready;
  assign in_vld_nxt = load || (in_vld_r && !proc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_ch_r  <= in_ch;
      in_has_r <= in_has_byte;
      in_eos_r <= in_end_of_source;
    end
  end

  stok_scan #(
    .POS_WIDTH  (POS_WIDTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .ch        (in_ch_r),
    .has_byte  (in_has_r),
    .eos       (in_eos_r),
    .rec_vld   (rec_vld),
    .rec_kind  (rec_kind),
    .rec_start (rec_start),
    .rec_len   (rec_len),
    .rec_line  (rec_line),
    .rec_last  (rec_last)
  );

  stok_rq #(
    .POS_WIDTH  (POS_WIDTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_rq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (proc),
    .rec_vld        (rec_vld),
    .rec_kind       (rec_kind),
    .rec_start      (rec_start),
    .rec_len        (rec_len),
    .rec_line       (rec_line),
    .rec_last       (rec_last),
    .room           (room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_start_pos  (out_start_pos),
    .out_token_len  (out_token_len),
    .out_line       (out_line),
    .out_last       (out_last)
  );

  // eof record exactly when the item ends the source
  a_eof_iff_end: assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (rec_vld[2] == in_eos_r))
    else $error("eof record does not follow end of source");

  // an empty item gives no record
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !in_has_r && !in_eos_r |-> rec_vld == '0)
    else $error("record from an item with no byte and no end");

  // a closed token needs a byte
  a_close_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    rec_vld[0] |-> in_has_r)
    else $error("token closed without a byte");

  // records pushed show up at the output next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    proc && (rec_vld != '0) |=> out_valid)
    else $error("pushed record not visible at output");

endmodule

`default_nettype wire
